@@ design/hrlp_pkg.sv @@
// Shared types and constants for the run-length plane decoder.
package hrlp_pkg;

    // Fixed field widths
    localparam int LEN_W   = 5;
    localparam int PLANE_W = 3;
    localparam int BYTE_W  = 8;
    localparam int REQ_W   = 2;
    localparam int ERR_W   = 2;

    // Parameter defaults
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int CODE_WIDTH_DEF  = 24;
    localparam int RUN_WIDTH_DEF   = 24;

    // Reset value of the maximum code length register
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 5'd24;

    // Request kinds carried in the input tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_PLANE = 2'd0,
        REQ_ENTRY = 2'd1,
        REQ_BYTE  = 2'd2
    } req_t;

    // Error kinds carried in the output tuser
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_TOO_LONG   = 2'd1,
        ERR_TABLE_FULL = 2'd2
    } err_kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_SCAN,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

    // Result handoff from the sequencer to the output register
    typedef struct packed {
        logic                 valid;
        logic                 last;
        err_kind_t            err;
        logic [PLANE_W-1:0]   plane;
        logic                 run_bit;
    } emit_t;

endpackage

@@ design/hrlp_table.sv @@
// Code table memory: one write port, one registered read port.
module hrlp_table #(
    parameter int TABLE_DEPTH = hrlp_pkg::TABLE_DEPTH_DEF,
    parameter int ENT_W       = 53,
    localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [ENT_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [ENT_W-1:0] wr_data
);
    import hrlp_pkg::*;

    logic [ENT_W-1:0] mem [TABLE_DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/hrlp_seq.sv @@
// Sequencer: table update, bit shifting and table scan with one shared comparator.
module hrlp_seq #(
    parameter int TABLE_DEPTH = hrlp_pkg::TABLE_DEPTH_DEF,
    parameter int CODE_WIDTH  = hrlp_pkg::CODE_WIDTH_DEF,
    parameter int RUN_WIDTH   = hrlp_pkg::RUN_WIDTH_DEF,
    localparam int IDX_W      = $clog2(TABLE_DEPTH),
    localparam int ENT_W      = hrlp_pkg::LEN_W + CODE_WIDTH + RUN_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input item
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [hrlp_pkg::REQ_W-1:0]   in_req,
    input  logic [hrlp_pkg::PLANE_W-1:0] in_plane,
    input  logic [hrlp_pkg::LEN_W-1:0]   in_len,
    input  logic [CODE_WIDTH-1:0]        in_code,
    input  logic [RUN_WIDTH-1:0]         in_value,
    input  logic [hrlp_pkg::BYTE_W-1:0]  in_byte,
    // effective maximum code length
    input  logic [hrlp_pkg::LEN_W-1:0]   limit,
    // result handoff
    output hrlp_pkg::emit_t              emit,
    output logic [RUN_WIDTH-1:0]         emit_run,
    input  logic                         emit_ready,
    // table memory
    output logic                         mem_rd_en,
    output logic [IDX_W-1:0]             mem_rd_addr,
    input  logic [ENT_W-1:0]             mem_rd_data,
    output logic                         mem_wr_en,
    output logic [IDX_W-1:0]             mem_wr_addr,
    output logic [ENT_W-1:0]             mem_wr_data
);
    import hrlp_pkg::*;

    state_t                state_reg, state_next;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic [2:0]            bit_idx_reg, bit_idx_next;
    logic [LEN_W-1:0]      key_len_reg, key_len_next;
    logic [CODE_WIDTH-1:0] key_bits_reg, key_bits_next;
    logic [RUN_WIDTH-1:0]  val_reg, val_next;
    logic [IDX_W:0]        count_reg, count_next;
    logic [IDX_W:0]        issue_reg, issue_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [RUN_WIDTH-1:0]  hit_val_reg, hit_val_next;
    logic [CODE_WIDTH-1:0] acc_bits_reg, acc_bits_next;
    logic [LEN_W-1:0]      acc_len_reg, acc_len_next;
    logic                  colour_reg, colour_next;
    logic [PLANE_W-1:0]    plane_reg, plane_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [RUN_WIDTH-1:0]  pend_run_reg, pend_run_next;
    err_kind_t             pend_err_reg, pend_err_next;
    logic                  pend_bit_reg, pend_bit_next;

    logic [LEN_W-1:0]      ent_len;
    logic [CODE_WIDTH-1:0] ent_code;
    logic [RUN_WIDTH-1:0]  ent_val;
    logic                  match;
    logic                  cur_bit;
    logic [CODE_WIDTH-1:0] cand_bits;
    logic [LEN_W-1:0]      cand_len;
    logic                  produce;
    logic                  go;

    // Entry fields of the word read last cycle
    assign ent_len  = mem_rd_data[ENT_W-1 -: LEN_W];
    assign ent_code = mem_rd_data[RUN_WIDTH +: CODE_WIDTH];
    assign ent_val  = mem_rd_data[RUN_WIDTH-1:0];

    // Shared comparator
    assign match = rd_pend_reg && (ent_len == key_len_reg) && (ent_code == key_bits_reg);

    // Accumulator with the next compressed bit added
    assign cur_bit  = byte_reg[bit_idx_reg];
    assign cand_len = acc_len_reg + 1'b1;
    always_comb begin
        for (int i = 0; i < CODE_WIDTH; i++) begin
            cand_bits[i] = acc_bits_reg[i] | (cur_bit && (acc_len_reg == LEN_W'(i)));
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            acc_bits_reg   <= '0;
            acc_len_reg    <= '0;
            colour_reg     <= 1'b0;
            plane_reg      <= '0;
            pend_valid_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            acc_bits_reg   <= acc_bits_next;
            acc_len_reg    <= acc_len_next;
            colour_reg     <= colour_next;
            plane_reg      <= plane_next;
            pend_valid_reg <= pend_valid_next;
            rd_pend_reg    <= rd_pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        byte_reg     <= byte_next;
        bit_idx_reg  <= bit_idx_next;
        key_len_reg  <= key_len_next;
        key_bits_reg <= key_bits_next;
        val_reg      <= val_next;
        issue_reg    <= issue_next;
        rd_idx_reg   <= rd_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_val_reg  <= hit_val_next;
        pend_run_reg <= pend_run_next;
        pend_err_reg <= pend_err_next;
        pend_bit_reg <= pend_bit_next;
    end

    // Next state and outputs
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        byte_next       = byte_reg;
        bit_idx_next    = bit_idx_reg;
        key_len_next    = key_len_reg;
        key_bits_next   = key_bits_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_val_next    = hit_val_reg;
        acc_bits_next   = acc_bits_reg;
        acc_len_next    = acc_len_reg;
        colour_next     = colour_reg;
        plane_next      = plane_reg;
        pend_valid_next = pend_valid_reg;
        pend_run_next   = pend_run_reg;
        pend_err_next   = pend_err_reg;
        pend_bit_next   = pend_bit_reg;

        in_ready      = 1'b0;
        emit.valid    = 1'b0;
        emit.last     = 1'b0;
        emit.err      = pend_err_reg;
        emit.plane    = plane_reg;
        emit.run_bit  = pend_bit_reg;
        emit_run      = pend_run_reg;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = issue_reg[IDX_W-1:0];
        mem_wr_en     = 1'b0;
        mem_wr_addr   = hit_idx_reg;
        mem_wr_data   = {key_len_reg, key_bits_reg, val_reg};
        produce       = hit_reg || (key_len_reg >= limit);
        go            = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    req_next = in_req;
                    case (in_req)
                        REQ_PLANE: begin
                            count_next    = '0;
                            acc_bits_next = '0;
                            acc_len_next  = '0;
                            colour_next   = 1'b0;
                            plane_next    = in_plane;
                        end
                        REQ_ENTRY: begin
                            key_len_next  = in_len;
                            key_bits_next = in_code;
                            val_next      = in_value;
                            issue_next    = '0;
                            state_next    = ST_SCAN;
                        end
                        REQ_BYTE: begin
                            byte_next    = in_byte;
                            bit_idx_next = '0;
                            state_next   = ST_BIT;
                        end
                        default: begin
                            // unused request: dropped
                        end
                    endcase
                end
            end
            ST_BIT: begin
                key_len_next  = cand_len;
                key_bits_next = cand_bits;
                issue_next    = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                // one entry compared per cycle, its read issued in the cycle before
                if (match) begin
                    hit_next     = 1'b1;
                    hit_idx_next = rd_idx_reg;
                    hit_val_next = ent_val;
                    state_next   = ST_DECIDE;
                end else if (issue_reg == count_reg) begin
                    hit_next   = 1'b0;
                    state_next = ST_DECIDE;
                end else begin
                    mem_rd_en    = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = issue_reg[IDX_W-1:0];
                    issue_next   = issue_reg + 1'b1;
                end
            end
            ST_DECIDE: begin
                if (req_reg == REQ_ENTRY) begin
                    if (hit_reg) begin
                        mem_wr_en  = 1'b1;
                        state_next = ST_IDLE;
                    end else if (count_reg < (IDX_W+1)'(TABLE_DEPTH)) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = count_reg[IDX_W-1:0];
                        count_next  = count_reg + 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        pend_valid_next = 1'b1;
                        pend_run_next   = '0;
                        pend_bit_next   = 1'b0;
                        pend_err_next   = ERR_TABLE_FULL;
                        state_next      = ST_FLUSH;
                    end
                end else begin
                    // a new result pushes out the held one, which is not last
                    if (produce && pend_valid_reg) begin
                        emit.valid = 1'b1;
                        go         = emit_ready;
                    end
                    if (go) begin
                        if (produce) begin
                            pend_valid_next = 1'b1;
                            pend_run_next   = hit_reg ? hit_val_reg : '0;
                            pend_bit_next   = hit_reg ? colour_reg : 1'b0;
                            pend_err_next   = hit_reg ? ERR_NONE : ERR_TOO_LONG;
                            if (hit_reg) begin
                                colour_next = ~colour_reg;
                            end
                            acc_bits_next = '0;
                            acc_len_next  = '0;
                        end else begin
                            acc_bits_next = key_bits_reg;
                            acc_len_next  = key_len_reg;
                        end
                        if (&bit_idx_reg) begin
                            state_next = ST_FLUSH;
                        end else begin
                            bit_idx_next = bit_idx_reg + 1'b1;
                            state_next   = ST_BIT;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (pend_valid_reg) begin
                    emit.valid = 1'b1;
                    emit.last  = 1'b1;
                    if (emit_ready) begin
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (IDX_W+1)'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_emit_held: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid |-> pend_valid_reg)
        else $error("result handed off with nothing held");

    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_len_reg < LEN_W'(CODE_WIDTH))
        else $error("accumulator length reached code width");

    a_append: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr_en && !hit_reg) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("new entry written without count advance");

endmodule

@@ design/huffman_run_length_plane_decoder.sv @@
// Run-length bit-plane decoder top level: streams, config register and output stage.
//
// Each compressed bit is appended to the accumulator and then compared against
// the stored entries one per cycle through the single read port of the table
// memory, stopping at the first match; a table item is scanned the same way.
// The input is not ready while an item is in work. A result is held in the
// sequencer and then in one output register, and a stall on the result side
// holds the sequencer when a new result must push out the held one or when the
// last result of an item is handed off.
module huffman_run_length_plane_decoder #(
    parameter int TABLE_DEPTH = hrlp_pkg::TABLE_DEPTH_DEF,
    parameter int CODE_WIDTH  = hrlp_pkg::CODE_WIDTH_DEF,
    parameter int RUN_WIDTH   = hrlp_pkg::RUN_WIDTH_DEF,
    localparam int IN_W  = ((16 + CODE_WIDTH + RUN_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((RUN_WIDTH + 4 + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [hrlp_pkg::LEN_W-1:0]  cfg_wr_data,    // max_code_length
    // input items
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // plane_number, entry_code_length, entry_code, entry_run_value, code_byte
    input  logic [IN_W-1:0]             s_axis_tdata,
    input  logic [hrlp_pkg::REQ_W-1:0]  s_axis_tuser,   // req_type
    // result items
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OUT_W-1:0]            m_axis_tdata,   // run_length, run_bit, run_plane
    output logic [hrlp_pkg::ERR_W-1:0]  m_axis_tuser,   // error_kind
    output logic                        m_axis_tlast    // last_of_item
);
    import hrlp_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int ENT_W   = LEN_W + CODE_WIDTH + RUN_WIDTH;
    localparam int OFS_LEN  = PLANE_W;
    localparam int OFS_CODE = OFS_LEN + LEN_W;
    localparam int OFS_VAL  = OFS_CODE + CODE_WIDTH;
    localparam int OFS_BYTE = OFS_VAL + RUN_WIDTH;

    logic [LEN_W-1:0]     max_len_reg;
    logic [LEN_W-1:0]     limit;

    emit_t                emit;
    logic [RUN_WIDTH-1:0] emit_run;
    logic                 emit_ready;

    logic                 mem_rd_en;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic [ENT_W-1:0]     mem_rd_data;
    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic [ENT_W-1:0]     mem_wr_data;

    logic                 out_valid_reg, out_valid_next;
    logic [RUN_WIDTH-1:0] out_run_reg;
    logic                 out_bit_reg;
    logic [PLANE_W-1:0]   out_plane_reg;
    err_kind_t            out_err_reg;
    logic                 out_last_reg;

    // Maximum code length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Effective limit: zero acts as one, capped at the code width
    always_comb begin
        if (max_len_reg == '0) begin
            limit = LEN_W'(1);
        end else if (max_len_reg > LEN_W'(CODE_WIDTH)) begin
            limit = LEN_W'(CODE_WIDTH);
        end else begin
            limit = max_len_reg;
        end
    end

    hrlp_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENT_W       (ENT_W)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    hrlp_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CODE_WIDTH  (CODE_WIDTH),
        .RUN_WIDTH   (RUN_WIDTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_req      (s_axis_tuser),
        .in_plane    (s_axis_tdata[PLANE_W-1:0]),
        .in_len      (s_axis_tdata[OFS_LEN +: LEN_W]),
        .in_code     (s_axis_tdata[OFS_CODE +: CODE_WIDTH]),
        .in_value    (s_axis_tdata[OFS_VAL +: RUN_WIDTH]),
        .in_byte     (s_axis_tdata[OFS_BYTE +: BYTE_W]),
        .limit       (limit),
        .emit        (emit),
        .emit_run    (emit_run),
        .emit_ready  (emit_ready),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    // Output register
    assign emit_ready = !out_valid_reg || m_axis_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit.valid && emit_ready) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid && emit_ready) begin
            out_run_reg   <= emit_run;
            out_bit_reg   <= emit.run_bit;
            out_plane_reg <= emit.plane;
            out_err_reg   <= emit.err;
            out_last_reg  <= emit.last;
        end
    end

    // Result packing
    always_comb begin
        m_axis_tdata                           = '0;
        m_axis_tdata[RUN_WIDTH-1:0]            = out_run_reg;
        m_axis_tdata[RUN_WIDTH]                = out_bit_reg;
        m_axis_tdata[RUN_WIDTH+1 +: PLANE_W]   = out_plane_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_err_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
